[rtl/core/smrt_pkg.sv]
// Shared types and constants for the sorted multiset rank table.
// No dependencies; every other file in rtl/core but smrt_store imports this package.
package smrt_pkg;

  // Default configuration of the table
  localparam int unsigned DEF_TABLE_DEPTH = 16;
  localparam int unsigned DEF_KEY_WIDTH   = 16;
  localparam int unsigned DEF_COUNT_WIDTH = 16;

  // Fixed field widths of the transfer payloads
  localparam int unsigned IN_KEY_W     = 16;
  localparam int unsigned OUT_COUNT_W  = 16;
  localparam int unsigned OUT_RANK_W   = 20;
  localparam int unsigned OUT_DIST_W   = 5;

  localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;
  localparam logic [OUT_RANK_W-1:0]  OUT_RANK_MAX  = '1;
  localparam logic [OUT_DIST_W-1:0]  OUT_DIST_MAX  = '1;

  // Opcodes; the unused code behaves as a query
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [IN_KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] count;
    logic [OUT_RANK_W-1:0]  rank;
    logic [OUT_DIST_W-1:0]  distinct_entries;
    logic [1:0]             status;
  } out_item_t;

endpackage

[rtl/core/sorted_multiset_rank_table.sv]
// Top level of the sorted multiset rank table: sequencer, store, output register.
// Depends on smrt_pkg, smrt_store, smrt_ctrl (and smrt_alu below it).
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   in      | sink      | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//   out     | source    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// One item at a time: the item is taken, then the scan reads each stored entry
// up to the first key not below it, then for a new key or a removed entry the
// entries beyond it are moved one place, then the result is handed over.
// The single read port of the entry store paces the scan and the moves.
// Reset empties the table at once; no clearing pass is run.
// A stalled result waits in the output register while the next item is taken.
module sorted_multiset_rank_table #(
  parameter int unsigned TABLE_DEPTH = smrt_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = smrt_pkg::DEF_KEY_WIDTH,
  parameter int unsigned COUNT_WIDTH = smrt_pkg::DEF_COUNT_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smrt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smrt_pkg::out_item_t out_data_o
);
  import smrt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic                   in_ready;
  logic                   res_valid, res_ready;
  out_item_t              res;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [KEY_WIDTH-1:0]   mem_wkey, mem_rkey;
  logic [COUNT_WIDTH-1:0] mem_wcnt, mem_rcnt;
  logic                   out_valid_q;
  out_item_t              out_data_q;

  smrt_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wkey_i  (mem_wkey),
    .wcnt_i  (mem_wcnt),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rkey_o  (mem_rkey),
    .rcnt_o  (mem_rcnt)
  );

  smrt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wkey_o  (mem_wkey),
    .mem_wcnt_o  (mem_wcnt),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rkey_i  (mem_rkey),
    .mem_rcnt_i  (mem_rcnt)
  );

  assign in_stall_o = !in_ready;

  // Output register takes a result when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/core/smrt_store.sv]
// Entry store: key and count memories, one write and one registered read port.
// Depends on nothing but the clock; contents are undefined until written.
module smrt_store #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_WIDTH   = 16,
  parameter int unsigned COUNT_WIDTH = 16,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [KEY_WIDTH-1:0]   wkey_i,
  input  logic [COUNT_WIDTH-1:0] wcnt_i,
  input  logic                   re_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [KEY_WIDTH-1:0]   rkey_o,
  output logic [COUNT_WIDTH-1:0] rcnt_o
);

  logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]   rkey_q;
  logic [COUNT_WIDTH-1:0] rcnt_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      cnt_mem[waddr_i] <= wcnt_i;
    end
  end

  // Registered read; hold the last word when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_q <= key_mem[raddr_i];
      rcnt_q <= cnt_mem[raddr_i];
    end
  end

  assign rkey_o = rkey_q;
  assign rcnt_o = rcnt_q;

endmodule

[rtl/core/smrt_alu.sv]
// Shared compare and saturating-add unit used on every scan step.
// Uses smrt_pkg for the rank width and its ceiling.
module smrt_alu #(
  parameter int unsigned KEY_WIDTH   = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic [KEY_WIDTH-1:0]              key_a_i,
  input  logic [KEY_WIDTH-1:0]              key_b_i,
  input  logic [smrt_pkg::OUT_RANK_W-1:0]   acc_i,
  input  logic [COUNT_WIDTH-1:0]            addend_i,
  output logic                              lt_o,
  output logic                              eq_o,
  output logic [smrt_pkg::OUT_RANK_W-1:0]   sum_o
);
  import smrt_pkg::*;

  localparam int unsigned SW = ((COUNT_WIDTH > OUT_RANK_W) ? COUNT_WIDTH : OUT_RANK_W) + 1;

  logic [SW-1:0] sum_full;

  // Signed key compare
  assign lt_o = $signed(key_a_i) < $signed(key_b_i);
  assign eq_o = key_a_i == key_b_i;

  // Accumulate, clamp at the rank ceiling
  assign sum_full = SW'(acc_i) + SW'(addend_i);
  assign sum_o    = (sum_full > SW'(OUT_RANK_MAX)) ? OUT_RANK_MAX : sum_full[OUT_RANK_W-1:0];

endmodule

[rtl/core/smrt_ctrl.sv]
// Sequencer: scans the sorted store, shifts entries and forms the result.
// Uses smrt_pkg and smrt_alu; drives the ports of smrt_store.
module smrt_ctrl #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_WIDTH   = 16,
  parameter int unsigned COUNT_WIDTH = 16,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  smrt_pkg::in_item_t     in_data_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output smrt_pkg::out_item_t    res_o,
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_waddr_o,
  output logic [KEY_WIDTH-1:0]   mem_wkey_o,
  output logic [COUNT_WIDTH-1:0] mem_wcnt_o,
  output logic                   mem_re_o,
  output logic [AW-1:0]          mem_raddr_o,
  input  logic [KEY_WIDTH-1:0]   mem_rkey_i,
  input  logic [COUNT_WIDTH-1:0] mem_rcnt_i
);
  import smrt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CEW   = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;
  localparam int unsigned DW    = (IDX_W > OUT_DIST_W) ? IDX_W : OUT_DIST_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_UP   = 5'b00100,
    S_DN   = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [1:0]              op_q;
  logic [KEY_WIDTH-1:0]    key_q;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic [IDX_W-1:0]        used_q, used_d;
  logic [OUT_RANK_W-1:0]   sum_q, sum_d;
  logic [COUNT_WIDTH-1:0]  rcnt_q, rcnt_d;
  logic                    hit_q, hit_d;
  logic [1:0]              status_q, status_d;

  logic                    take;
  logic                    alu_lt, alu_eq;
  logic [OUT_RANK_W-1:0]   alu_sum;
  logic [IDX_W-1:0]        idx_inc, idx_dec, idx_dec2, pos_inc;
  logic                    stop_hit, stop_end, found;
  logic [IDX_W-1:0]        s_pos;
  logic [CEW-1:0]          cnt_ext;
  logic [DW-1:0]           used_ext;

  smrt_alu #(
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_alu (
    .key_a_i  (mem_rkey_i),
    .key_b_i  (key_q),
    .acc_i    (sum_q),
    .addend_i (mem_rcnt_i),
    .lt_o     (alu_lt),
    .eq_o     (alu_eq),
    .sum_o    (alu_sum)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign take       = in_valid_i && in_ready_o;

  assign idx_inc  = idx_q + IDX_W'(1);
  assign idx_dec  = idx_q - IDX_W'(1);
  assign idx_dec2 = idx_q - IDX_W'(2);
  assign pos_inc  = s_pos + IDX_W'(1);

  // Scan stop: first entry not below the key, or end of the used range
  assign stop_hit = pend_q && !alu_lt;
  assign stop_end = !stop_hit && (idx_q == used_q);
  assign found    = stop_hit && alu_eq;
  assign s_pos    = stop_hit ? idx_dec : idx_q;

  // Next-state and datapath control
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pos_d       = pos_q;
    used_d      = used_q;
    sum_d       = sum_q;
    rcnt_d      = rcnt_q;
    hit_d       = hit_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = s_pos[AW-1:0];
    mem_wkey_o  = key_q;
    mem_wcnt_o  = mem_rcnt_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (take) begin
          idx_d    = '0;
          pend_d   = 1'b0;
          sum_d    = '0;
          status_d = ST_OK;
          hit_d    = 1'b0;
          state_d  = S_SCAN;
        end
      end

      S_SCAN: begin
        // Add in the count of a smaller key
        if (pend_q && alu_lt) begin
          sum_d = alu_sum;
        end
        if (stop_hit || stop_end) begin
          pos_d   = s_pos;
          state_d = S_DONE;
          case (op_q)
            OP_INSERT: begin
              if (found) begin
                hit_d = 1'b1;
                if (mem_rcnt_i == CNT_MAX) begin
                  status_d = ST_SAT;
                  rcnt_d   = mem_rcnt_i;
                end else begin
                  rcnt_d     = mem_rcnt_i + CNT_ONE;
                  mem_we_o   = 1'b1;
                  mem_wcnt_o = mem_rcnt_i + CNT_ONE;
                end
              end else if (used_q == IDX_W'(TABLE_DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                // Open a slot: move entries up from the top
                hit_d   = 1'b1;
                rcnt_d  = CNT_ONE;
                idx_d   = used_q;
                pend_d  = 1'b0;
                state_d = S_UP;
              end
            end
            OP_DELETE: begin
              if (!found) begin
                status_d = ST_ABSENT;
              end else if (mem_rcnt_i != CNT_ONE) begin
                hit_d      = 1'b1;
                rcnt_d     = mem_rcnt_i - CNT_ONE;
                mem_we_o   = 1'b1;
                mem_wcnt_o = mem_rcnt_i - CNT_ONE;
              end else begin
                // Last occurrence: close the gap
                idx_d   = pos_inc;
                pend_d  = 1'b0;
                state_d = S_DN;
              end
            end
            default: begin
              if (found) begin
                hit_d  = 1'b1;
                rcnt_d = mem_rcnt_i;
              end else begin
                status_d = ST_ABSENT;
              end
            end
          endcase
        end else begin
          // Fetch the next entry
          mem_re_o = 1'b1;
          idx_d    = idx_inc;
          pend_d   = 1'b1;
        end
      end

      S_UP: begin
        // Write the entry fetched last cycle one place higher
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_inc[AW-1:0];
          mem_wkey_o  = mem_rkey_i;
          mem_wcnt_o  = mem_rcnt_i;
        end
        if (idx_q > pos_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_dec[AW-1:0];
          idx_d       = idx_dec;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        // Place the new key once the move has drained
        if (!pend_q && (idx_q == pos_q)) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q[AW-1:0];
          mem_wkey_o  = key_q;
          mem_wcnt_o  = CNT_ONE;
          used_d      = used_q + IDX_W'(1);
          state_d     = S_DONE;
        end
      end

      S_DN: begin
        // Write the entry fetched last cycle one place lower
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_dec2[AW-1:0];
          mem_wkey_o  = mem_rkey_i;
          mem_wcnt_o  = mem_rcnt_i;
        end
        if (idx_q < used_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AW-1:0];
          idx_d       = idx_inc;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (!pend_q && (idx_q >= used_q)) begin
          used_d  = used_q - IDX_W'(1);
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      pos_q    <= '0;
      used_q   <= '0;
      sum_q    <= '0;
      rcnt_q   <= '0;
      hit_q    <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      pos_q    <= pos_d;
      used_q   <= used_d;
      sum_q    <= sum_d;
      rcnt_q   <= rcnt_d;
      hit_q    <= hit_d;
      status_q <= status_d;
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q  <= in_data_i.opcode;
      key_q <= KEY_WIDTH'(in_data_i.key);
    end
  end

  // Result fields, clamped to the output widths
  assign cnt_ext  = hit_q ? CEW'(rcnt_q) : '0;
  assign used_ext = DW'(used_q);

  always_comb begin
    res_o.count = (cnt_ext > CEW'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : cnt_ext[OUT_COUNT_W-1:0];
    if (!hit_q) begin
      res_o.rank = '0;
    end else if (sum_q == OUT_RANK_MAX) begin
      res_o.rank = OUT_RANK_MAX;
    end else begin
      res_o.rank = sum_q + OUT_RANK_W'(1);
    end
    res_o.distinct_entries = (used_ext > DW'(OUT_DIST_MAX)) ? OUT_DIST_MAX
                                                             : used_ext[OUT_DIST_W-1:0];
    res_o.status = status_q;
  end

endmodule

[rtl/core/smrt_checker.sv]
// Port-level checks for sorted_multiset_rank_table, bound to the top level.
// Depends on smrt_pkg for payload types and status codes.
module smrt_checker #(
  parameter int unsigned TABLE_DEPTH = smrt_pkg::DEF_TABLE_DEPTH
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input smrt_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input smrt_pkg::out_item_t out_data_o
);
  import smrt_pkg::*;

  localparam int unsigned DMAX = (TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH;

  // Held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // One item at a time: stall rises after every input transfer
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // Count and rank are zero together
  a_cnt_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.count == '0) == (out_data_o.rank == '0)))
    else $error("count and rank disagree on presence");

  // Dropped or absent results carry no count
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL || out_data_o.status == ST_ABSENT)
    |-> out_data_o.count == '0 && out_data_o.rank == '0)
    else $error("miss result with nonzero count or rank");

  // Entry count never exceeds the table size
  a_distinct_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.distinct_entries <= OUT_DIST_W'(DMAX))
    else $error("distinct entries beyond table size");

endmodule

bind sorted_multiset_rank_table smrt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_smrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[tb/sv/sorted_multiset_rank_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sorted_multiset_rank_table: directed and random transfers,
// each result checked against a shadow copy of the sorted table kept here.
// Depends on smrt_pkg and the RTL of the table only.
module sorted_multiset_rank_table_tb;
  import smrt_pkg::*;

  localparam int unsigned DEPTH       = DEF_TABLE_DEPTH;
  localparam int unsigned COUNT_TOP   = (1 << DEF_COUNT_WIDTH) - 1;
  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam int          TAIL_CYCLES = 60;
  localparam int          POOL_SIZE   = 20;
  localparam int          GROW_ITEMS  = 40;
  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam logic signed [IN_KEY_W-1:0] KEY_MIN = 16'sh8000;
  localparam logic signed [IN_KEY_W-1:0] KEY_MAX = 16'sh7fff;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // Shadow of the table contents, ascending keys in entries 0 to held_n-1
  logic signed [IN_KEY_W-1:0] held_key [DEPTH];
  int unsigned                held_cnt [DEPTH];
  int unsigned                held_n = 0;

  out_item_t awaited_results [$];
  int        mismatches = 0;
  int        cycles     = 0;
  int        stall_run  = 0;
  bit        hush       = 1'b0;

  sorted_multiset_rank_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_multiset_rank_table test failed");
      $finish;
    end
  end

  // Stall the result channel in runs, mostly short, sometimes long
  always @(negedge clk_i) begin
    if (hush) begin
      stall_run = 0;
    end else if (stall_run == 0 && $urandom_range(0, 99) < 30) begin
      stall_run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 24);
    end
    out_stall_i <= (stall_run > 0);
    if (stall_run > 0) stall_run--;
  end

  // Apply one operation to the shadow table and return the result it should give
  function automatic out_item_t shadow_table_op(logic [1:0] op, logic signed [IN_KEY_W-1:0] key);
    int unsigned       pos;
    int unsigned       i;
    bit                hit;
    logic [1:0]        st;
    longint unsigned   below;
    longint unsigned   cnt;
    longint unsigned   rk;
    out_item_t         res;
    pos = 0;
    while (pos < held_n && held_key[pos] < key) pos++;
    hit = (pos < held_n) && (held_key[pos] == key);
    st  = ST_OK;
    case (op)
      OP_INSERT: begin
        if (hit) begin
          if (held_cnt[pos] >= COUNT_TOP) st = ST_SAT;
          else held_cnt[pos]++;
        end else if (held_n >= DEPTH) begin
          st = ST_FULL;
        end else begin
          for (i = held_n; i > pos; i--) begin
            held_key[i] = held_key[i-1];
            held_cnt[i] = held_cnt[i-1];
          end
          held_key[pos] = key;
          held_cnt[pos] = 1;
          held_n++;
          hit = 1'b1;
        end
      end
      OP_DELETE: begin
        if (!hit) begin
          st = ST_ABSENT;
        end else if (held_cnt[pos] > 1) begin
          held_cnt[pos]--;
        end else begin
          for (i = pos; i + 1 < held_n; i++) begin
            held_key[i] = held_key[i+1];
            held_cnt[i] = held_cnt[i+1];
          end
          held_n--;
          hit = 1'b0;
        end
      end
      // query and the spare code change nothing
      default: begin
        if (!hit) st = ST_ABSENT;
      end
    endcase
    cnt = 0;
    rk  = 0;
    if (hit) begin
      below = 0;
      for (i = 0; i < pos; i++) below += held_cnt[i];
      cnt = held_cnt[pos];
      rk  = below + 1;
    end
    res.count            = (cnt > OUT_COUNT_MAX) ? OUT_COUNT_MAX : OUT_COUNT_W'(cnt);
    res.rank             = (rk > OUT_RANK_MAX) ? OUT_RANK_MAX : OUT_RANK_W'(rk);
    res.distinct_entries = (held_n > OUT_DIST_MAX) ? OUT_DIST_MAX : OUT_DIST_W'(held_n);
    res.status           = st;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (hush || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Present one transfer, hold it until taken, then record its expected result
  task automatic send_item(logic [1:0] op, logic signed [IN_KEY_W-1:0] key);
    int       gap;
    in_item_t item;
    gap = pick_gap();
    item.opcode = op;
    item.key    = key;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(shadow_table_op(op, key));
  endtask

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result, count field", 0, out_data_o.count);
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.count !== want.count)
          note_mismatch("count", want.count, out_data_o.count);
        if (out_data_o.rank !== want.rank)
          note_mismatch("rank", want.rank, out_data_o.rank);
        if (out_data_o.distinct_entries !== want.distinct_entries)
          note_mismatch("distinct_entries", want.distinct_entries, out_data_o.distinct_entries);
        if (out_data_o.status !== want.status)
          note_mismatch("status", want.status, out_data_o.status);
      end
    end
  end

  // Absent keys on an empty table, including the spare opcode
  task automatic test_empty_table();
    send_item(OP_QUERY, 16'sd5);
    send_item(OP_DELETE, -16'sd5);
    send_item(OP_SPARE, 16'sd123);
  endtask

  // Key extremes, a repeated insert and ranks over them
  task automatic test_key_extremes();
    send_item(OP_INSERT, KEY_MAX);
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, 16'sd0);
    send_item(OP_INSERT, -16'sd1);
    send_item(OP_INSERT, 16'sd0);
    send_item(OP_QUERY, KEY_MAX);
    send_item(OP_SPARE, 16'sd0);
  endtask

  // Remove the head, a middle entry after a decrement, and the tail
  task automatic test_removal();
    send_item(OP_DELETE, KEY_MIN);
    send_item(OP_DELETE, 16'sd0);
    send_item(OP_DELETE, 16'sd0);
    send_item(OP_DELETE, KEY_MAX);
  endtask

  // Fill the table, then a new key is dropped and a held one still counts up
  task automatic test_full_table();
    int i;
    for (i = 0; i < 15; i++) send_item(OP_INSERT, 16'(signed'((i - 7) * 3001)));
    send_item(OP_INSERT, 16'sd12345);
    send_item(OP_INSERT, 16'sd3001);
  endtask

  // Build a high count on the head key back-to-back, then step it down and up
  task automatic test_count_growth();
    int i;
    while (held_n >= DEPTH && held_key[0] != KEY_MIN)
      send_item(OP_DELETE, held_key[held_n-1]);
    hush = 1'b1;
    for (i = 0; i < GROW_ITEMS; i++) send_item(OP_INSERT, KEY_MIN);
    hush = 1'b0;
    send_item(OP_QUERY, KEY_MIN);
    send_item(OP_DELETE, KEY_MIN);
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, KEY_MIN);
  endtask

  function automatic logic signed [IN_KEY_W-1:0] pick_key(
    input logic signed [IN_KEY_W-1:0] pool [POOL_SIZE], input bit prefer_held);
    int r;
    r = $urandom_range(0, 99);
    if (prefer_held && held_n > 0 && r < 60) return held_key[$urandom_range(0, held_n - 1)];
    if (r < 75) return pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    return IN_KEY_W'($urandom);
  endfunction

  // Random traffic over a small key pool so that hits, full table and removals recur
  task automatic test_random_phase(int n_items, int ins_pct, int del_pct);
    logic signed [IN_KEY_W-1:0] pool [POOL_SIZE];
    logic [1:0]                 op;
    int                         r;
    int                         i;
    for (i = 0; i < POOL_SIZE; i++) pool[i] = IN_KEY_W'($urandom);
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 0) hush = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < ins_pct) op = OP_INSERT;
      else if (r < ins_pct + del_pct) op = OP_DELETE;
      else if (r < 96) op = OP_QUERY;
      else op = OP_SPARE;
      send_item(op, pick_key(pool, op != OP_INSERT));
    end
    hush = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_key_extremes();
    test_removal();
    test_full_table();
    test_count_growth();
    test_random_phase(400, 60, 25);
    test_random_phase(400, 40, 40);
    test_random_phase(350, 25, 60);

    // Drain outstanding results, then keep watching over TAIL_CYCLES for strays
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("sorted_multiset_rank_table test passed");
    end else begin
      $display("sorted_multiset_rank_table test failed");
    end
    $finish;
  end

endmodule
